@@ sv/cfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame size parser package
// Shared widths, register indexes, header tables and the decoded frame record.
// ----------------------------------------------------------------------------
package cfsp_pkg;

   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned RATE_W     = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ENCODING_RATE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_LAYER_RATE = 4'd1;

   // Highest rate index that still gives a valid frame.
   localparam logic [RATE_W-1:0] MAX_RATE = 3'd5;

   typedef struct packed {
      logic [RATE_W-1:0] encoding_rate;
      logic [RATE_W-1:0] core_layer_rate;
   } cfg_type;

   // Everything the layer sequencer needs to emit the results of one frame.
   typedef struct packed {
      logic              frame_ok;
      logic              is_speech;
      logic [9:0]        total_bits;
      logic [2:0]        layer_count;
      logic [6:0]        class_a_bits;
      logic [4:0]        class_b_bits;
      logic [4:0]        class_c_bits;
      logic [6:0]        class_d_bits;
      logic [6:0]        class_f_bits;
      logic [7:0]        core_bits;
      logic [RATE_W-1:0] last_index;
      logic              row;
   } frm_type;

   typedef struct packed {
      logic       frame_ok;
      logic       is_speech;
      logic [9:0] total_bits;
      logic [2:0] layer_count;
      logic [6:0] class_a_bits;
      logic [4:0] class_b_bits;
      logic [4:0] class_c_bits;
      logic [6:0] class_d_bits;
      logic [6:0] class_f_bits;
      logic [2:0] layer_index;
      logic [7:0] layer_bits;
      logic       last_layer;
   } rsp_type;

   function automatic logic [3:0] pair_bits(input logic [1:0] sel);
      logic [3:0] val;
      unique case (sel)
         2'd0: val = 4'd0;
         2'd1: val = 4'd9;
         2'd2: val = 4'd9;
         2'd3: val = 4'd15;
         default: val = 4'd0;
      endcase
      return val;
   endfunction

   function automatic logic [5:0] fixed_bits(input logic [3:0] sel);
      logic [5:0] val;
      unique case (sel)
         4'd0:  val = 6'd43;
         4'd1:  val = 6'd50;
         4'd2:  val = 6'd36;
         4'd3:  val = 6'd31;
         4'd4:  val = 6'd46;
         4'd5:  val = 6'd48;
         4'd6:  val = 6'd40;
         4'd7:  val = 6'd44;
         4'd8:  val = 6'd47;
         4'd9:  val = 6'd43;
         4'd10: val = 6'd44;
         4'd11: val = 6'd45;
         4'd12: val = 6'd43;
         4'd13: val = 6'd44;
         4'd14: val = 6'd47;
         4'd15: val = 6'd36;
         default: val = 6'd0;
      endcase
      return val;
   endfunction

   // Per-layer base counts; row 1 is used once both the core layer rate and the encoding rate are non-zero.
   function automatic logic [5:0] layer_tab(input logic row, input logic [RATE_W-1:0] idx);
      logic [5:0] val;
      unique case (idx)
         3'd0:    val = row ? 6'd25 : 6'd13;
         3'd1:    val = row ? 6'd0  : 6'd11;
         3'd2:    val = 6'd23;
         3'd3:    val = row ? 6'd32 : 6'd33;
         3'd4:    val = 6'd36;
         3'd5:    val = 6'd31;
         default: val = 6'd0;
      endcase
      return val;
   endfunction

   // Sum of the table entries of layers 1 up to and including rate.
   function automatic logic [7:0] layer_sum(input logic row, input logic [RATE_W-1:0] rate);
      logic [7:0] acc;
      acc = 8'd0;
      for (int unsigned k = 1; k <= 5; k++) begin
         if (RATE_W'(k) <= rate) begin
            acc = acc + {2'b00, layer_tab(row, RATE_W'(k))};
         end
      end
      return acc;
   endfunction

endpackage

@@ sv/cfsp_req_if.sv @@
// ----------------------------------------------------------------------------
// Frame header channel
// Valid/ready channel carrying the two header bytes and the frame byte count.
// ----------------------------------------------------------------------------
interface cfsp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  header_low;
   logic [7:0]  header_high;
   logic [11:0] byte_count;

   modport source (output valid, header_low, header_high, byte_count, input ready);
   modport sink   (input valid, header_low, header_high, byte_count, output ready);
endinterface

@@ sv/cfsp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Layer result channel
// Valid/ready channel carrying one layer description with the frame totals.
// ----------------------------------------------------------------------------
interface cfsp_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_ok;
   logic       is_speech;
   logic [9:0] total_bits;
   logic [2:0] layer_count;
   logic [6:0] class_a_bits;
   logic [4:0] class_b_bits;
   logic [4:0] class_c_bits;
   logic [6:0] class_d_bits;
   logic [6:0] class_f_bits;
   logic [2:0] layer_index;
   logic [7:0] layer_bits;
   logic       last_layer;

   modport source (output valid, frame_ok, is_speech, total_bits, layer_count,
                   class_a_bits, class_b_bits, class_c_bits, class_d_bits,
                   class_f_bits, layer_index, layer_bits, last_layer,
                   input ready);
   modport sink   (input valid, frame_ok, is_speech, total_bits, layer_count,
                   class_a_bits, class_b_bits, class_c_bits, class_d_bits,
                   class_f_bits, layer_index, layer_bits, last_layer,
                   output ready);
endinterface

@@ sv/cfsp_csr_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cfsp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cfsp_pkg::CSR_IDX_W-1:0]  index;
   logic [cfsp_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cfsp_csr.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the encoding rate and the core layer rate.
// ----------------------------------------------------------------------------
module cfsp_csr (
   input  logic              clock,
   input  logic              reset,
   cfsp_csr_if.sink          csr_bus,
   output cfsp_pkg::cfg_type cfg
);

   cfsp_pkg::cfg_type cfg_ff;
   cfsp_pkg::cfg_type cfg_in;
   logic              wr;

   assign csr_bus.ready = 1'b1;
   assign wr            = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_bus.index)
            cfsp_pkg::REG_ENCODING_RATE:
               cfg_in.encoding_rate = csr_bus.data[cfsp_pkg::RATE_W-1:0];
            cfsp_pkg::REG_CORE_LAYER_RATE:
               cfg_in.core_layer_rate = csr_bus.data[cfsp_pkg::RATE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/cfsp_decode.sv @@
// ----------------------------------------------------------------------------
// Header decoder
// Works out class and layer bit counts of one frame from its header bytes.
// ----------------------------------------------------------------------------
module cfsp_decode (
   input  logic [7:0]        header_low,
   input  logic [7:0]        header_high,
   input  logic [11:0]       byte_count,
   input  cfsp_pkg::cfg_type cfg,
   output cfsp_pkg::frm_type frm
);

   logic [15:0]                 hdr;
   logic                        speech;
   logic                        bad;
   logic [2:0]                  f1;
   logic [2:0]                  f2;
   logic [cfsp_pkg::RATE_W-1:0] base;
   logic                        row;
   logic [6:0]                  ca_spch;
   logic [6:0]                  ca_sid;
   logic [4:0]                  cb;
   logic [4:0]                  cc;
   logic [6:0]                  cd;
   logic [6:0]                  cf;
   logic [8:0]                  lay0;
   logic [9:0]                  total;

   assign hdr    = {header_high, header_low};
   assign speech = hdr[0];
   assign bad    = (cfg.encoding_rate > cfsp_pkg::MAX_RATE) || (byte_count == 12'd0) ||
                   (speech && (byte_count < 12'd2));

   assign f1 = {2'b00, hdr[1]} + {2'b00, hdr[3]} + {2'b00, hdr[5]} + {2'b00, hdr[7]};
   assign f2 = {2'b00, hdr[2]} + {2'b00, hdr[4]} + {2'b00, hdr[6]} + {2'b00, hdr[8]};

   assign base = (cfg.core_layer_rate > cfg.encoding_rate) ? cfg.encoding_rate
                                                          : cfg.core_layer_rate;
   assign row  = (base != '0);

   assign ca_spch = 7'd15 + {1'b0, cfsp_pkg::fixed_bits(hdr[14:11])};
   assign ca_sid  = 7'd10 + {1'b0, cfsp_pkg::fixed_bits(hdr[4:1])};
   assign cb      = {1'b0, cfsp_pkg::pair_bits({hdr[5], hdr[7]})} +
                    {1'b0, cfsp_pkg::pair_bits({hdr[1], hdr[3]})};
   assign cc      = {2'b00, f1} * 5'd5;
   assign cd      = {4'b0000, f2} * 7'd30;
   assign cf      = {4'b0000, 3'd4 - f2} * {1'b0, cfsp_pkg::layer_tab(row, 3'd0)};

   // The core layer carries the sum of the sensitivity classes.
   assign lay0  = {2'b00, ca_spch} + {4'b0000, cb} + {4'b0000, cc} + {2'b00, cd} +
                  {2'b00, cf};
   assign total = {1'b0, lay0} +
                  {cfsp_pkg::layer_sum(row, cfg.encoding_rate), 2'b00};

   always_comb begin
      frm = '0;
      if (bad) begin
         frm = '0;
      end else if (!speech) begin
         // A silence descriptor has only the core layer and only class A.
         frm.frame_ok     = 1'b1;
         frm.layer_count  = 3'd1;
         frm.class_a_bits = ca_sid;
         frm.total_bits   = {3'b000, ca_sid};
         frm.core_bits    = {1'b0, ca_sid};
      end else begin
         frm.frame_ok     = 1'b1;
         frm.is_speech    = 1'b1;
         frm.total_bits   = total;
         frm.layer_count  = cfg.encoding_rate + 3'd1;
         frm.class_a_bits = ca_spch;
         frm.class_b_bits = cb;
         frm.class_c_bits = cc;
         frm.class_d_bits = cd;
         frm.class_f_bits = cf;
         frm.core_bits    = lay0[7:0];
         frm.last_index   = cfg.encoding_rate;
         frm.row          = row;
      end
   end

endmodule

@@ sv/cfsp_emit.sv @@
// ----------------------------------------------------------------------------
// Layer sequencer
// Holds one decoded frame and sends its layer results through an output register.
// ----------------------------------------------------------------------------
module cfsp_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              frm_load,
   input  cfsp_pkg::frm_type frm_d,
   output logic              frm_free,
   cfsp_rsp_if.source        rsp_bus
);

   cfsp_pkg::frm_type           frm_ff;
   logic                        frm_vld_ff;
   logic                        frm_vld_in;
   logic [cfsp_pkg::RATE_W-1:0] idx_ff;
   logic [cfsp_pkg::RATE_W-1:0] idx_in;
   cfsp_pkg::rsp_type           out_ff;
   cfsp_pkg::rsp_type           out_in;
   logic                        out_vld_ff;
   logic                        out_vld_in;
   logic                        out_load;
   logic                        last;
   logic                        done;

   assign out_load = frm_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign last     = (idx_ff == frm_ff.last_index);
   assign done     = out_load && last;
   assign frm_free = !frm_vld_ff || done;

   assign frm_vld_in = frm_load ? 1'b1 : (done ? 1'b0 : frm_vld_ff);
   assign idx_in     = frm_load ? '0 : (out_load ? idx_ff + 3'd1 : idx_ff);
   assign out_vld_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_vld_ff);

   always_comb begin
      out_in              = out_ff;
      if (out_load) begin
         out_in.frame_ok     = frm_ff.frame_ok;
         out_in.is_speech    = frm_ff.is_speech;
         out_in.total_bits   = frm_ff.total_bits;
         out_in.layer_count  = frm_ff.layer_count;
         out_in.class_a_bits = frm_ff.class_a_bits;
         out_in.class_b_bits = frm_ff.class_b_bits;
         out_in.class_c_bits = frm_ff.class_c_bits;
         out_in.class_d_bits = frm_ff.class_d_bits;
         out_in.class_f_bits = frm_ff.class_f_bits;
         out_in.layer_index  = idx_ff;
         out_in.layer_bits   = (idx_ff == '0) ? frm_ff.core_bits
                               : {cfsp_pkg::layer_tab(frm_ff.row, idx_ff), 2'b00};
         out_in.last_layer   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         frm_vld_ff <= frm_vld_in;
         out_vld_ff <= out_vld_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frm_load) begin
         frm_ff <= frm_d;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.frame_ok     = out_ff.frame_ok;
   assign rsp_bus.is_speech    = out_ff.is_speech;
   assign rsp_bus.total_bits   = out_ff.total_bits;
   assign rsp_bus.layer_count  = out_ff.layer_count;
   assign rsp_bus.class_a_bits = out_ff.class_a_bits;
   assign rsp_bus.class_b_bits = out_ff.class_b_bits;
   assign rsp_bus.class_c_bits = out_ff.class_c_bits;
   assign rsp_bus.class_d_bits = out_ff.class_d_bits;
   assign rsp_bus.class_f_bits = out_ff.class_f_bits;
   assign rsp_bus.layer_index  = out_ff.layer_index;
   assign rsp_bus.layer_bits   = out_ff.layer_bits;
   assign rsp_bus.last_layer   = out_ff.last_layer;

endmodule

@@ sv/codec_frame_size_parser.sv @@
// ----------------------------------------------------------------------------
// Codec frame size parser
// Decodes a layered speech codec frame header into class and layer bit counts.
// ----------------------------------------------------------------------------
// Each accepted item (two header bytes and a byte count) yields one result per
// layer, from one to six, and exactly one result with frame_ok low when the
// encoding rate is above 5 or the frame is too short. The first result passes
// the input register, the frame register of the layer sequencer and the output
// register; results then follow one per cycle while the output is not stalled,
// a frame holds the layer sequencer until its last layer result is loaded,
// and the next item enters while the current one is still being sent.
// Configuration should be written only when the block is idle.
module codec_frame_size_parser (
   input  logic     clock,
   input  logic     reset,
   cfsp_req_if.sink   req_bus,
   cfsp_rsp_if.source rsp_bus,
   cfsp_csr_if.sink   csr_bus
);

   cfsp_pkg::cfg_type cfg;
   cfsp_pkg::frm_type frm;
   logic              in_vld_ff;
   logic              in_vld_in;
   logic [7:0]        hdr_low_ff;
   logic [7:0]        hdr_high_ff;
   logic [11:0]       bytes_ff;
   logic              req_take;
   logic              frm_free;
   logic              frm_load;

   assign frm_load      = in_vld_ff && frm_free;
   assign req_bus.ready = !in_vld_ff || frm_free;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign in_vld_in     = req_take || (in_vld_ff && !frm_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hdr_low_ff  <= req_bus.header_low;
         hdr_high_ff <= req_bus.header_high;
         bytes_ff    <= req_bus.byte_count;
      end
   end

   cfsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   cfsp_decode u_decode (
      .header_low  (hdr_low_ff),
      .header_high (hdr_high_ff),
      .byte_count  (bytes_ff),
      .cfg         (cfg),
      .frm         (frm)
   );

   cfsp_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .frm_load (frm_load),
      .frm_d    (frm),
      .frm_free (frm_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
